FILE: sv/bfs_pkg.sv
`timescale 1ns / 1ps
// Package for the breadth-first walk block: sizes, codes and beat types.
// No dependencies.
package bfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;

  localparam int VERT_W  = 6;
  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int QCNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VCMP_W  = VERT_W + 1;
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_REFUSED = 2'd1,
    KIND_VISIT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              mode;
    logic [VERT_W-1:0] src_vertex;
    logic [VERT_W-1:0] dst_vertex;
  } req_t;

  typedef struct packed {
    kind_t             kind;
    logic [VERT_W-1:0] vertex;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [VERT_W-1:0] src;
    logic [VERT_W-1:0] dst;
  } edge_t;

endpackage

FILE: sv/graph_bfs_order.sv
`timescale 1ns / 1ps
// Breadth-first walk over a stored directed edge list, from vertex 0.
// Depends on bfs_pkg.
//
//  channel | dir | handshake           | beat
//  req     | in  | req_valid/req_stall | req_t: mode, src_vertex, dst_vertex
//  rsp     | out | rsp_valid/rsp_stall | rsp_t: kind, vertex, last
//
// Add-edge beats load back to back while the rsp channel is not stalled.
// A walk makes one pass over the stored edges for each vertex that it dequeues,
// through the edge memory read port.
// Reset is synchronous and needs no clearing pass; the edge and queue memories
// are only read below their fill marks.
// A stalled rsp beat holds the walk at its next report; req is stalled throughout a walk.
module graph_bfs_order
  import bfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t               state, state_next;
  logic [ECNT_W-1:0]    edge_count;
  logic [ECNT_W-1:0]    scan_idx;
  logic                 rd_valid;
  logic [QCNT_W-1:0]    head, tail;
  logic [MAX_VERTICES-1:0] visited;
  logic [VERT_W-1:0]    cur;

  edge_t                edge_mem [MAX_EDGES];
  edge_t                edge_rd;
  logic [VERT_W-1:0]    queue_mem [MAX_VERTICES];
  logic [VERT_W-1:0]    queue_rd;

  logic rsp_free, accept, add_go, run_go, refuse, scan_issue, scan_done;
  logic emit_go, q_empty, hit;

  assign rsp_free = !rsp_valid || !rsp_stall;
  assign q_empty  = (head == tail);
  assign hit      = rd_valid && (edge_rd.src == cur) && !visited[edge_rd.dst[VIDX_W-1:0]];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (req_valid && rsp_free && req.mode == MODE_RUN) state_next = ST_SCAN;
      ST_SCAN: if (scan_done) state_next = ST_EMIT;
      ST_EMIT: if (rsp_free) state_next = q_empty ? ST_IDLE : ST_LOAD;
      ST_LOAD: state_next = ST_SCAN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != ST_IDLE) || !rsp_free;
    accept     = req_valid && !req_stall;
    add_go     = accept && (req.mode == MODE_ADD);
    run_go     = accept && (req.mode == MODE_RUN);
    refuse     = (VCMP_W'(req.src_vertex) >= VCMP_W'(MAX_VERTICES)) ||
                 (VCMP_W'(req.dst_vertex) >= VCMP_W'(MAX_VERTICES)) ||
                 (edge_count >= ECNT_W'(MAX_EDGES));
    scan_issue = (state == ST_SCAN) && (scan_idx != edge_count);
    scan_done  = (state == ST_SCAN) && (scan_idx == edge_count) && !rd_valid;
    emit_go    = (state == ST_EMIT) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (add_go && !refuse) begin
      edge_mem[edge_count[EDGE_AW-1:0]] <= '{src: req.src_vertex, dst: req.dst_vertex};
    end
    edge_rd <= edge_mem[scan_idx[EDGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      queue_mem[tail[VIDX_W-1:0]] <= edge_rd.dst;
    end
    queue_rd <= queue_mem[head[VIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (add_go) begin
      rsp <= '{kind: refuse ? KIND_REFUSED : KIND_STORED, vertex: '0, last: 1'b1};
    end else if (emit_go) begin
      rsp <= '{kind: KIND_VISIT, vertex: cur, last: q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rsp_valid  <= 1'b0;
      edge_count <= '0;
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      head       <= '0;
      tail       <= '0;
      visited    <= '0;
      cur        <= '0;
    end else begin
      state <= state_next;

      if (add_go || emit_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (add_go && !refuse) begin
        edge_count <= edge_count + 1'b1;
      end

      if (run_go) begin
        visited    <= MAX_VERTICES'(1);
        head       <= QCNT_W'(1);
        tail       <= QCNT_W'(1);
        cur        <= '0;
        scan_idx   <= '0;
        rd_valid   <= 1'b0;
      end else begin
        rd_valid <= scan_issue;
        if (scan_issue) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (hit) begin
          visited[edge_rd.dst[VIDX_W-1:0]] <= 1'b1;
          tail <= tail + 1'b1;
        end
        if (emit_go && !q_empty) begin
          head <= head + 1'b1;
        end
        if (state == ST_LOAD) begin
          cur      <= queue_rd;
          scan_idx <= '0;
        end
      end
    end
  end

endmodule

FILE: sv/bfs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for graph_bfs_order, bound to every instance.
// Depends on bfs_pkg.
module bfs_checker
  import bfs_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp beat dropped or changed while stalled");

  a_add_reply: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.mode == MODE_ADD |=>
      rsp_valid && rsp.last && rsp.vertex == '0 &&
      (rsp.kind == KIND_STORED || rsp.kind == KIND_REFUSED))
    else $error("add-edge beat without its single reply");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != KIND_VISIT |-> rsp.last)
    else $error("edge reply without last");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.mode == MODE_RUN |=> req_stall)
    else $error("req taken during a walk");

endmodule

bind graph_bfs_order bfs_checker u_bfs_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for graph_bfs_order: edge loads, store overflow and
// breadth-first walks from vertex 0, predicted by a scoreboard class.
// Depends on bfs_pkg and graph_bfs_order.
module tb_top
  import bfs_pkg::*;
();

  localparam int LIMIT = 20_000_000;

  class bfs_board;
    logic [VERT_W-1:0] edge_src [MAX_EDGES];
    logic [VERT_W-1:0] edge_dst [MAX_EDGES];
    int edge_total = 0;
    int errors = 0;
    rsp_t pending_replies [$];

    function void note_request(req_t b);
      bit seen [MAX_VERTICES];
      logic [VERT_W-1:0] order [$];
      logic [VERT_W-1:0] cur;
      rsp_t r;
      int head;
      head = 0;
      r.vertex = '0;
      r.last = 1'b1;
      if (b.mode == MODE_ADD) begin
        if (int'(b.src_vertex) >= MAX_VERTICES || int'(b.dst_vertex) >= MAX_VERTICES ||
            edge_total >= MAX_EDGES) begin
          r.kind = KIND_REFUSED;
        end else begin
          edge_src[edge_total] = b.src_vertex;
          edge_dst[edge_total] = b.dst_vertex;
          edge_total++;
          r.kind = KIND_STORED;
        end
        pending_replies = {pending_replies, r};
        return;
      end
      order = {order, VERT_W'(0)};
      seen[0] = 1'b1;
      while (head < order.size()) begin
        cur = order[head];
        head++;
        for (int e = 0; e < edge_total; e++) begin
          if (edge_src[e] == cur && !seen[edge_dst[e]]) begin
            seen[edge_dst[e]] = 1'b1;
            order = {order, edge_dst[e]};
          end
        end
      end
      foreach (order[i]) begin
        r.kind = KIND_VISIT;
        r.vertex = order[i];
        r.last = (i == order.size() - 1);
        pending_replies = {pending_replies, r};
      end
    endfunction

    function void check_reply(rsp_t got);
      rsp_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected rsp beat: kind %0d vertex %0d last %0d",
                   got.kind, got.vertex, got.last);
        return;
      end
      want = pending_replies.pop_front();
      if (got.kind !== want.kind || got.vertex !== want.vertex || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"rsp mismatch: expected kind %0d vertex %0d last %0d, ",
                    "got kind %0d vertex %0d last %0d"},
                   want.kind, want.vertex, want.last, got.kind, got.vertex, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic quiet = 1'b0;
  int cycles = 0;
  bfs_board board = new();

  graph_bfs_order u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall)
        board.check_reply(rsp);
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 32);
    end
  end

  task automatic send_beat(input req_t b);
    if (!quiet)
      while ($urandom_range(0, 99) < 32) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    req_valid <= 1'b1;
    req <= b;
    do @(posedge clk); while (req_stall);
    board.note_request(b);
  endtask

  task automatic add_edge(input int s, input int d);
    req_t b;
    b.mode = MODE_ADD;
    b.src_vertex = s[VERT_W-1:0];
    b.dst_vertex = d[VERT_W-1:0];
    send_beat(b);
  endtask

  task automatic run_walk;
    req_t b;
    b.mode = MODE_RUN;
    b.src_vertex = VERT_W'($urandom_range(0, 63));
    b.dst_vertex = VERT_W'($urandom_range(0, 63));
    send_beat(b);
  endtask

  task automatic wait_drained;
    req_valid <= 1'b0;
    while (board.pending_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    int span, s, d, last_s, last_d;
    last_s = 0;
    last_d = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty graph, self loop, extremes, duplicate, alternating bit patterns
    run_walk;
    add_edge(0, 0);
    run_walk;
    add_edge(0, 63);
    add_edge(63, 63);
    add_edge(63, 0);
    add_edge(0, 63);
    add_edge(63, 42);
    add_edge(42, 21);
    add_edge(21, 1);
    add_edge(1, 62);
    run_walk;
    wait_drained;

    for (int i = 0; i < 220; i++) begin
      quiet <= (i >= 90 && i < 150);
      span = (i / 3 + 2 > 63) ? 63 : i / 3 + 2;
      if ($urandom_range(0, 99) < 9) begin
        run_walk;
      end else if ($urandom_range(0, 99) < 8) begin
        add_edge(last_s, last_d);
      end else begin
        if ($urandom_range(0, 99) < 70) begin
          s = $urandom_range(0, span);
          d = $urandom_range(0, span + 8 > 63 ? 63 : span + 8);
        end else begin
          s = $urandom_range(0, 63);
          d = $urandom_range(0, 63);
        end
        last_s = s;
        last_d = d;
        add_edge(s, d);
      end
    end
    quiet <= 1'b0;

    // fill the edge store, then overflow it
    while (board.edge_total < MAX_EDGES)
      add_edge($urandom_range(0, 63), $urandom_range(0, 63));
    repeat (3) add_edge($urandom_range(0, 63), $urandom_range(0, 63));
    run_walk;

    wait_drained;
    repeat (64) @(posedge clk);
    if (board.errors == 0 && board.pending_replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
